### src/fixed_width_int_to_decimal_ascii_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the decimal text converter
// Clocked assertion forms used by the checker file.
// ----------------------------------------------------------------------------
`ifndef FIXED_WIDTH_INT_TO_DECIMAL_ASCII_ASSERT_SVH
`define FIXED_WIDTH_INT_TO_DECIMAL_ASCII_ASSERT_SVH

// Check a property outside of reset.
`define FWDA_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property at every edge, reset included.
`define FWDA_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### src/fwda_pkg.sv
// ----------------------------------------------------------------------------
// fwda_pkg
// Types and constants shared by the decimal text converter.
// ----------------------------------------------------------------------------
package fwda_pkg;

    localparam int DIGIT_BITS    = 4;  // one BCD digit
    localparam int STEP_BITS     = 4;  // binary bits folded into the BCD per cycle
    localparam int CHAR_BITS     = 8;
    localparam int CFG_DATA_BITS = 4;  // widest register

    typedef logic [CHAR_BITS-1:0]  char_t;
    typedef logic [DIGIT_BITS-1:0] digit_t;

    localparam char_t CH_ZERO  = 8'h30;
    localparam char_t CH_PLUS  = 8'h2B;
    localparam char_t CH_MINUS = 8'h2D;

    // Add-3 correction keeps each digit below the radix of ten after doubling
    localparam digit_t DABBLE_LIMIT = 4'd5;
    localparam digit_t DABBLE_ADD   = 4'd3;

    typedef enum logic [0:0] {
        REG_FIELD_WIDTH = 1'b0,
        REG_SIGN_MODE   = 1'b1
    } cfg_index_t;

    localparam logic [CFG_DATA_BITS-1:0] FIELD_WIDTH_RST = 4'd10;
    localparam logic                     SIGN_MODE_RST   = 1'b0;

endpackage

### src/fixed_width_int_to_decimal_ascii.sv
// ----------------------------------------------------------------------------
// fixed_width_int_to_decimal_ascii
// Converts a signed integer into a fixed-width run of decimal ASCII characters.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream (s_tvalid/s_tready/s_tdata) takes one two's complement value
//   per request. Master stream (m_tvalid/m_tready/m_tdata/m_tlast) returns
//   field_width characters (clamped to 1..MAX_CHARS), most significant first, m_tlast on the final one.
//   Config channel (cfg_valid/cfg_ready/cfg_index/cfg_data) is always ready;
//   write it only while no value is in flight.
// Timing:
//   After a value is taken the shared BCD unit folds four bits of the
//   magnitude per cycle until all of it is in BCD, then one character
//   loads per cycle into the output register while the receiver is ready;
//   s_tready stays low from the taken value until the last character loads.
// Reset:
//   rst_n clears the sequencer and the output register and sets field_width
//   to 10 and sign_mode to 0.
// Stalls:
//   A held m_tready freezes the pending character; the sequencer waits and
//   nothing is dropped. The next value may be taken while the final
//   character of the previous run still waits in the output register.
// ----------------------------------------------------------------------------
module fixed_width_int_to_decimal_ascii #(
    parameter int VALUE_BITS = 32,
    parameter int MAX_CHARS  = 11
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    // value (VALUE_BITS, signed), zero padded to whole bytes
    input  logic                                   s_tvalid,
    output logic                                   s_tready,
    input  logic [((VALUE_BITS+7)/8)*8-1:0]        s_tdata,
    // char_code (8)
    output logic                                   m_tvalid,
    input  logic                                   m_tready,
    output logic [fwda_pkg::CHAR_BITS-1:0]         m_tdata,
    output logic                                   m_tlast,
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  fwda_pkg::cfg_index_t                   cfg_index,
    input  logic [fwda_pkg::CFG_DATA_BITS-1:0]     cfg_data
);
    import fwda_pkg::*;

    localparam int MAG_BITS = ((VALUE_BITS + STEP_BITS - 1) / STEP_BITS) * STEP_BITS;
    localparam int STEPS    = MAG_BITS / STEP_BITS;
    localparam int SCW      = $clog2(STEPS);
    localparam int BCD_BITS = MAX_CHARS * DIGIT_BITS;
    localparam int CW       = $clog2(MAX_CHARS + 1);
    localparam int DIW      = $clog2(MAX_CHARS);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONV,
        ST_EMIT
    } state_t;

    // Registers
    state_t                     state_reg,     state_next;
    logic [SCW-1:0]             step_cnt_reg,  step_cnt_next;
    logic [DIW-1:0]             idx_reg,       idx_next;
    logic                       sign_pend_reg, sign_pend_next;
    logic                       m_tvalid_reg,  m_tvalid_next;
    char_t                      m_tdata_reg,   m_tdata_next;
    logic                       m_tlast_reg,   m_tlast_next;
    logic [CFG_DATA_BITS-1:0]   field_width_reg;
    logic                       sign_mode_reg;
    logic [MAG_BITS-1:0]        mag_reg;
    logic [BCD_BITS-1:0]        bcd_reg;
    logic                       neg_reg;
    logic                       nodig_reg;

    // Accept-side combinational values
    logic [VALUE_BITS-1:0]      value_w;
    logic                       neg_w;
    logic [VALUE_BITS-1:0]      mag_w;
    logic [CW-1:0]              width_w;
    logic [CW-1:0]              ndig_w;
    logic                       accept_w;
    logic                       slot_free_w;
    logic [BCD_BITS-1:0]        bcd_step_w;
    digit_t                     digit_w;

    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;
    assign m_tlast   = m_tlast_reg;

    assign accept_w    = s_tvalid && s_tready;
    assign slot_free_w = !m_tvalid_reg || m_tready;

    // Magnitude of the value; the most negative code maps to 2^(VALUE_BITS-1)
    assign value_w = s_tdata[VALUE_BITS-1:0];
    assign neg_w   = value_w[VALUE_BITS-1];
    assign mag_w   = neg_w ? VALUE_BITS'(~value_w + 1'b1) : value_w;

    // Clamp the requested width: zero reads as one, anything past MAX_CHARS saturates
    always_comb
    begin
        if (field_width_reg == '0)
        begin
            width_w = CW'(1);
        end
        else if (int'(field_width_reg) > MAX_CHARS)
        begin
            width_w = CW'(MAX_CHARS);
        end
        else
        begin
            width_w = CW'(field_width_reg);
        end
        ndig_w = width_w - CW'(sign_mode_reg);
    end

    // Shared BCD unit, fed from the top of the magnitude shifter
    fwda_dabble #(
        .NDIG (MAX_CHARS)
    ) u_dabble (
        .bcd_in  (bcd_reg),
        .bits_in (mag_reg[MAG_BITS-1 -: STEP_BITS]),
        .bcd_out (bcd_step_w)
    );

    assign digit_w = bcd_reg[idx_reg*DIGIT_BITS +: DIGIT_BITS];

    // Sequencer next state
    always_comb
    begin
        state_next     = state_reg;
        step_cnt_next  = step_cnt_reg;
        idx_next       = idx_reg;
        sign_pend_next = sign_pend_reg;
        m_tvalid_next  = m_tvalid_reg;
        m_tdata_next   = m_tdata_reg;
        m_tlast_next   = m_tlast_reg;

        // Drop the character once the receiver takes it
        if (m_tvalid_reg && m_tready)
        begin
            m_tvalid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (accept_w)
                begin
                    state_next     = ST_CONV;
                    step_cnt_next  = SCW'(STEPS - 1);
                    sign_pend_next = sign_mode_reg;
                    idx_next       = DIW'(ndig_w - 1'b1);
                end
            end
            ST_CONV:
            begin
                if (step_cnt_reg == '0)
                begin
                    state_next = ST_EMIT;
                end
                else
                begin
                    step_cnt_next = step_cnt_reg - 1'b1;
                end
            end
            ST_EMIT:
            begin
                if (slot_free_w)
                begin
                    m_tvalid_next = 1'b1;
                    if (sign_pend_reg)
                    begin
                        // Sign leads; it closes the run when no digit follows
                        m_tdata_next   = neg_reg ? CH_MINUS : CH_PLUS;
                        m_tlast_next   = nodig_reg;
                        sign_pend_next = 1'b0;
                    end
                    else
                    begin
                        m_tdata_next = CH_ZERO + char_t'(digit_w);
                        m_tlast_next = (idx_reg == '0);
                        if (idx_reg != '0)
                        begin
                            idx_next = idx_reg - 1'b1;
                        end
                    end
                    if (m_tlast_next)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            step_cnt_reg  <= '0;
            idx_reg       <= '0;
            sign_pend_reg <= 1'b0;
            m_tvalid_reg  <= 1'b0;
            m_tdata_reg   <= '0;
            m_tlast_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_cnt_reg  <= step_cnt_next;
            idx_reg       <= idx_next;
            sign_pend_reg <= sign_pend_next;
            m_tvalid_reg  <= m_tvalid_next;
            m_tdata_reg   <= m_tdata_next;
            m_tlast_reg   <= m_tlast_next;
        end
    end

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            field_width_reg <= FIELD_WIDTH_RST;
            sign_mode_reg   <= SIGN_MODE_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_FIELD_WIDTH: field_width_reg <= cfg_data;
                REG_SIGN_MODE:   sign_mode_reg   <= cfg_data[0];
                default:         ;
            endcase
        end
    end

    // Datapath: load magnitude on request, then fold it into BCD four bits a cycle
    always_ff @(posedge clk)
    begin
        if (accept_w)
        begin
            mag_reg   <= MAG_BITS'(mag_w);
            bcd_reg   <= '0;
            neg_reg   <= neg_w;
            nodig_reg <= (ndig_w == '0);
        end
        else if (state_reg == ST_CONV)
        begin
            mag_reg <= mag_reg << STEP_BITS;
            bcd_reg <= bcd_step_w;
        end
    end

endmodule

### src/fwda_dabble.sv
// ----------------------------------------------------------------------------
// fwda_dabble
// Shift-and-add-3 step: folds STEP_BITS binary bits, MSB first, into a BCD word.
// ----------------------------------------------------------------------------
module fwda_dabble #(
    parameter int NDIG = 11
) (
    input  logic [NDIG*fwda_pkg::DIGIT_BITS-1:0] bcd_in,
    input  logic [fwda_pkg::STEP_BITS-1:0]       bits_in,
    output logic [NDIG*fwda_pkg::DIGIT_BITS-1:0] bcd_out
);
    import fwda_pkg::*;

    localparam int BCD_BITS = NDIG * DIGIT_BITS;

    logic [BCD_BITS-1:0] acc;

    // Carry out of the top digit is dropped: the word keeps value mod 10^NDIG
    always_comb
    begin
        acc = bcd_in;
        for (int b = STEP_BITS - 1; b >= 0; b--)
        begin
            for (int d = 0; d < NDIG; d++)
            begin
                if (acc[d*DIGIT_BITS +: DIGIT_BITS] >= DABBLE_LIMIT)
                begin
                    acc[d*DIGIT_BITS +: DIGIT_BITS] =
                        acc[d*DIGIT_BITS +: DIGIT_BITS] + DABBLE_ADD;
                end
            end
            acc = {acc[BCD_BITS-2:0], bits_in[b]};
        end
        bcd_out = acc;
    end

endmodule

### src/fwda_checker.sv
// ----------------------------------------------------------------------------
// fwda_checker
// Port-level checks for the decimal text converter, bound to the top level.
// ----------------------------------------------------------------------------
`include "fixed_width_int_to_decimal_ascii_assert.svh"

module fwda_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       s_tvalid,
    input logic       s_tready,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata,
    input logic       m_tlast
);
    import fwda_pkg::*;

    // A stalled character holds
    `FWDA_ASSERT(a_out_hold, clk, rst_n,
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast),
        "stalled character changed")

    // A taken value keeps the block busy on the following cycle
    `FWDA_ASSERT(a_busy_after_req, clk, rst_n,
        s_tvalid && s_tready |=> !s_tready,
        "request taken while converting")

    // Only digits and sign characters leave the block
    `FWDA_ASSERT(a_char_set, clk, rst_n,
        m_tvalid |-> ((m_tdata >= CH_ZERO && m_tdata < CH_ZERO + char_t'(10))
                      || m_tdata == CH_PLUS || m_tdata == CH_MINUS),
        "character outside digit and sign set")

    // An edge seen in reset leaves the output quiet on the next edge
    `FWDA_ASSERT_ALWAYS(a_reset_quiet, clk,
        !rst_n |=> !m_tvalid,
        "output valid during reset")

endmodule

bind fixed_width_int_to_decimal_ascii fwda_checker u_fwda_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);
